### hw/rtl/sit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg
// Types, widths and codes shared by the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int BOX_TOL_W   = 23;
    localparam int COL_TOL_W   = 48;
    localparam int CFG_INDEX_W = 8;

    // Derived datapath widths.
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CMP_W   = ((PROD_W + 1 > COL_TOL_W + 1) ? PROD_W + 1 : COL_TOL_W + 1) + 1;
    localparam int BOUND_W = ((COORD_WIDTH > BOX_TOL_W) ? COORD_WIDTH : BOX_TOL_W) + 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BOX_TOL = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_TOL = CFG_INDEX_W'(1);

    localparam logic [BOX_TOL_W-1:0] BOX_TOL_RESET = BOX_TOL_W'(410);
    localparam logic [COL_TOL_W-1:0] COL_TOL_RESET = COL_TOL_W'(1677722);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        coord_t first_start_x;
        coord_t first_start_y;
        coord_t first_end_x;
        coord_t first_end_y;
        coord_t second_start_x;
        coord_t second_start_y;
        coord_t second_end_x;
        coord_t second_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic       intersects;
        logic [2:0] decided_by;
    } result_t;

    typedef struct packed {
        logic [BOX_TOL_W-1:0] box_tol;
        logic [COL_TOL_W-1:0] col_tol;
    } tol_t;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } pipe_en_t;

    typedef enum logic [1:0] {
        ORIENT_COLLINEAR = 2'd0,
        ORIENT_CW        = 2'd1,
        ORIENT_CCW       = 2'd2
    } orient_t;

    typedef enum logic [2:0] {
        DEC_NONE         = 3'd0,
        DEC_CROSS        = 3'd1,
        DEC_P2_ON_FIRST  = 3'd2,
        DEC_Q2_ON_FIRST  = 3'd3,
        DEC_P1_ON_SECOND = 3'd4,
        DEC_Q1_ON_SECOND = 3'd5
    } decide_t;

endpackage

### hw/rtl/sit_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_cfg
// Tolerance registers written through the configuration channel.
// ----------------------------------------------------------------------------
module sit_cfg
    import sit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COL_TOL_W-1:0]   cfg_data,
    output tol_t                   tol
);

    tol_t tol_reg;
    tol_t tol_next;

    always_comb
    begin
        tol_next = tol_reg;
        if (cfg_valid)
        begin
            // Writes to an index beyond the register list are dropped.
            if (cfg_index == CFG_BOX_TOL)
            begin
                tol_next.box_tol = cfg_data[BOX_TOL_W-1:0];
            end
            else if (cfg_index == CFG_COL_TOL)
            begin
                tol_next.col_tol = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg.box_tol <= BOX_TOL_RESET;
            tol_reg.col_tol <= COL_TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    assign tol = tol_reg;

endmodule

### hw/rtl/sit_orient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_orient
// Three-stage orientation of a point triple: differences, products, and the
// cross product compared against the collinear band.
// ----------------------------------------------------------------------------
module sit_orient
    import sit_pkg::*;
(
    input  logic                 clk,
    input  pipe_en_t             en,
    input  point_t               p,
    input  point_t               q,
    input  point_t               r,
    input  logic [COL_TOL_W-1:0] col_tol,
    output orient_t              orient
);

    logic signed [DIFF_W-1:0] dqy_reg, drx_reg, dqx_reg, dry_reg;
    logic signed [DIFF_W-1:0] dqy_next, drx_next, dqx_next, dry_next;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [PROD_W-1:0] prod_a_next, prod_b_next;
    logic signed [CMP_W-1:0]  xprod;
    logic signed [CMP_W-1:0]  tol_pos;
    logic signed [CMP_W-1:0]  tol_neg;
    orient_t                  orient_reg;
    orient_t                  orient_next;

    function automatic logic signed [DIFF_W-1:0] sx(input coord_t v);
        sx = $signed({v[COORD_WIDTH-1], v});
    endfunction

    always_comb
    begin
        dqy_next = sx(q.y) - sx(p.y);
        drx_next = sx(r.x) - sx(q.x);
        dqx_next = sx(q.x) - sx(p.x);
        dry_next = sx(r.y) - sx(q.y);
    end

    always_comb
    begin
        prod_a_next = dqy_reg * drx_reg;
        prod_b_next = dqx_reg * dry_reg;
    end

    always_comb
    begin
        xprod   = $signed({{(CMP_W-PROD_W){prod_a_reg[PROD_W-1]}}, prod_a_reg})
                - $signed({{(CMP_W-PROD_W){prod_b_reg[PROD_W-1]}}, prod_b_reg});
        tol_pos = $signed({{(CMP_W-COL_TOL_W){1'b0}}, col_tol});
        tol_neg = -tol_pos;
        if (xprod > tol_pos)
        begin
            orient_next = ORIENT_CW;
        end
        else if (xprod < tol_neg)
        begin
            orient_next = ORIENT_CCW;
        end
        else
        begin
            orient_next = ORIENT_COLLINEAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.load1)
        begin
            dqy_reg <= dqy_next;
            drx_reg <= drx_next;
            dqx_reg <= dqx_next;
            dry_reg <= dry_next;
        end
        if (en.load2)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (en.load3)
        begin
            orient_reg <= orient_next;
        end
    end

    assign orient = orient_reg;

endmodule

### hw/rtl/sit_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_box
// Widened bounding box test of one point against the box of two corners,
// timed to line up with the orientation result.
// ----------------------------------------------------------------------------
module sit_box
    import sit_pkg::*;
(
    input  logic                 clk,
    input  pipe_en_t             en,
    input  point_t               corner_a,
    input  point_t               corner_b,
    input  point_t               pt,
    input  logic [BOX_TOL_W-1:0] box_tol,
    output logic                 covered
);

    logic signed [BOUND_W-1:0] hx_reg, lx_reg, hy_reg, ly_reg;
    logic signed [BOUND_W-1:0] hx_next, lx_next, hy_next, ly_next;
    logic signed [BOUND_W-1:0] ax, ay, bx, by, tol_ext;
    logic signed [BOUND_W-1:0] px_reg, py_reg;
    logic                      inside_s2_reg, inside_s3_reg;
    logic                      inside_s2_next;

    function automatic logic signed [BOUND_W-1:0] sx(input coord_t v);
        sx = $signed({{(BOUND_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v});
    endfunction

    always_comb
    begin
        ax      = sx(corner_a.x);
        ay      = sx(corner_a.y);
        bx      = sx(corner_b.x);
        by      = sx(corner_b.y);
        tol_ext = $signed({{(BOUND_W-BOX_TOL_W){1'b0}}, box_tol});
        hx_next = ((ax > bx) ? ax : bx) + tol_ext;
        lx_next = ((ax < bx) ? ax : bx) - tol_ext;
        hy_next = ((ay > by) ? ay : by) + tol_ext;
        ly_next = ((ay < by) ? ay : by) - tol_ext;
    end

    assign inside_s2_next = (px_reg <= hx_reg) && (px_reg >= lx_reg)
                         && (py_reg <= hy_reg) && (py_reg >= ly_reg);

    always_ff @(posedge clk)
    begin
        if (en.load1)
        begin
            hx_reg <= hx_next;
            lx_reg <= lx_next;
            hy_reg <= hy_next;
            ly_reg <= ly_next;
            px_reg <= sx(pt.x);
            py_reg <= sx(pt.y);
        end
        if (en.load2)
        begin
            inside_s2_reg <= inside_s2_next;
        end
        if (en.load3)
        begin
            inside_s3_reg <= inside_s2_reg;
        end
    end

    assign covered = inside_s3_reg;

endmodule

### hw/rtl/segment_intersection_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_test
// Orientation-based intersection test of two 2-D segments, fully pipelined.
// ----------------------------------------------------------------------------
// A seg beat accepted on an edge reaches res_valid through the difference,
// multiply, cross-product compare and decision registers, in that order.
// Throughput: one segment pair per cycle; each stage moves whenever the one
// after it is empty or moving, so a held result stalls without loss.
// Reset clears all valid bits and loads the default tolerances.
// ----------------------------------------------------------------------------
module segment_intersection_test
    import sit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   seg_valid,
    output logic                   seg_ready,
    input  seg_pair_t              seg,
    output logic                   res_valid,
    input  logic                   res_ready,
    output result_t                res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COL_TOL_W-1:0]   cfg_data
);

    tol_t     tol;
    pipe_en_t en;
    point_t   p1, q1, p2, q2;
    orient_t  o1, o2, o3, o4;
    logic     b2, b3, b4, b5;
    logic     ready1, ready2, ready3, ready4;
    logic     v1_reg, v2_reg, v3_reg, res_valid_reg;
    logic     v1_next, v2_next, v3_next, res_valid_next;
    decide_t  decide;
    result_t  res_reg;
    result_t  res_next;

    assign cfg_ready = 1'b1;

    sit_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tol       (tol)
    );

    assign p1 = '{x: seg.first_start_x,  y: seg.first_start_y};
    assign q1 = '{x: seg.first_end_x,    y: seg.first_end_y};
    assign p2 = '{x: seg.second_start_x, y: seg.second_start_y};
    assign q2 = '{x: seg.second_end_x,   y: seg.second_end_y};

    // Stage control: a stage loads when it is empty or its contents move on.
    assign ready4 = !res_valid_reg || res_ready;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign en.load1 = ready1;
    assign en.load2 = ready2;
    assign en.load3 = ready3;
    assign seg_ready = ready1;

    assign v1_next        = ready1 ? seg_valid : v1_reg;
    assign v2_next        = ready2 ? v1_reg : v2_reg;
    assign v3_next        = ready3 ? v2_reg : v3_reg;
    assign res_valid_next = ready4 ? v3_reg : res_valid_reg;

    sit_orient u_orient1 (.clk(clk), .en(en), .p(p1), .q(q1), .r(p2),
                          .col_tol(tol.col_tol), .orient(o1));
    sit_orient u_orient2 (.clk(clk), .en(en), .p(p1), .q(q1), .r(q2),
                          .col_tol(tol.col_tol), .orient(o2));
    sit_orient u_orient3 (.clk(clk), .en(en), .p(p2), .q(q2), .r(p1),
                          .col_tol(tol.col_tol), .orient(o3));
    sit_orient u_orient4 (.clk(clk), .en(en), .p(p2), .q(q2), .r(q1),
                          .col_tol(tol.col_tol), .orient(o4));

    sit_box u_box2 (.clk(clk), .en(en), .corner_a(p1), .corner_b(q1), .pt(p2),
                    .box_tol(tol.box_tol), .covered(b2));
    sit_box u_box3 (.clk(clk), .en(en), .corner_a(p1), .corner_b(q1), .pt(q2),
                    .box_tol(tol.box_tol), .covered(b3));
    sit_box u_box4 (.clk(clk), .en(en), .corner_a(p2), .corner_b(q2), .pt(p1),
                    .box_tol(tol.box_tol), .covered(b4));
    sit_box u_box5 (.clk(clk), .en(en), .corner_a(p2), .corner_b(q2), .pt(q1),
                    .box_tol(tol.box_tol), .covered(b5));

    // The general crossing wins; otherwise the endpoint cases are tried in order.
    always_comb
    begin
        priority if (o1 != o2 && o3 != o4)
        begin
            decide = DEC_CROSS;
        end
        else if (o1 == ORIENT_COLLINEAR && b2)
        begin
            decide = DEC_P2_ON_FIRST;
        end
        else if (o2 == ORIENT_COLLINEAR && b3)
        begin
            decide = DEC_Q2_ON_FIRST;
        end
        else if (o3 == ORIENT_COLLINEAR && b4)
        begin
            decide = DEC_P1_ON_SECOND;
        end
        else if (o4 == ORIENT_COLLINEAR && b5)
        begin
            decide = DEC_Q1_ON_SECOND;
        end
        else
        begin
            decide = DEC_NONE;
        end
        res_next.intersects = (decide != DEC_NONE);
        res_next.decided_by = decide;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### hw/rtl/sit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks on the segment intersection pipeline.
// ----------------------------------------------------------------------------
module sit_checker
    import sit_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      seg_valid,
    input logic      seg_ready,
    input logic      res_valid,
    input logic      res_ready,
    input result_t   res
);

    // A held result beat keeps its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.intersects == (res.decided_by != DEC_NONE))
                      && (res.decided_by <= DEC_Q1_ON_SECOND))
        else $error("intersects flag and decision code disagree");

    // The input side only backs up when the whole pipeline is full and stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !seg_ready |-> res_valid && !res_ready)
        else $error("input stalled without an output stall");

    // After a beat enters, a result is on offer at the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |-> ##4 res_valid)
        else $error("no result four cycles after an accepted pair");

endmodule

bind segment_intersection_test sit_checker u_checker (.*);
